// ----- rtl/btiq_pkg.sv -----
// shared types, constants and zone lookup for the button and touch input qualifier
`default_nettype none

package btiq_pkg;

  localparam int COORD_BITS = 10;
  localparam int KEY_BITS   = 7;
  localparam int TIME_BITS  = 32;
  localparam int TMO_BITS   = 16;
  localparam int TRAV_BITS  = 10;
  localparam int CFG_BITS   = 16;
  localparam int NUM_ZONES  = 6;

  // key bit positions in key_state
  localparam int K_BACK    = 0;
  localparam int K_CONFIRM = 1;
  localparam int K_LEFT    = 2;
  localparam int K_RIGHT   = 3;
  localparam int K_UP      = 4;
  localparam int K_DOWN    = 5;
  localparam int K_POWER   = 6;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TAP_TIMEOUT = 1'b0,
    REG_TAP_TRAVEL  = 1'b1
  } cfg_reg_t;

  localparam int ZONE_X0  [NUM_ZONES] = '{40, 480, 840, 40, 840, 880};
  localparam int ZONE_Y0  [NUM_ZONES] = '{480, 480, 480, 240, 240, 40};
  localparam int ZONE_W   [NUM_ZONES] = '{80, 80, 80, 80, 80, 80};
  localparam int ZONE_H   [NUM_ZONES] = '{40, 40, 40, 40, 40, 40};
  localparam int ZONE_KEY [NUM_ZONES] = '{K_LEFT, K_CONFIRM, K_RIGHT, K_UP, K_DOWN, K_BACK};

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [KEY_BITS-1:0]   keys_t;
  typedef logic [TIME_BITS-1:0]  ms_t;

  // one classified tick as it travels from front to back
  typedef struct packed {
    logic   enabled;
    logic   down;
    coord_t col;
    coord_t row;
    keys_t  phys_keys;
    keys_t  zone_keys;
    ms_t    now;
  } tick_t;

  // key of the first rectangle that holds the point, first match wins
  function automatic keys_t zone_bit(input coord_t x, input coord_t y);
    keys_t res;
    logic  found;
    res   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_ZONES; i++) begin
      if (!found &&
          int'(x) >= ZONE_X0[i] && int'(x) < ZONE_X0[i] + ZONE_W[i] &&
          int'(y) >= ZONE_Y0[i] && int'(y) < ZONE_Y0[i] + ZONE_H[i]) begin
        res[ZONE_KEY[i]] = 1'b1;
        found            = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/btiq_front.sv -----
// front end: unpacks a poll word, merges physical keys and looks up the touch zone
`default_nettype none

module btiq_front
  import btiq_pkg::*;
(
  input  wire logic [63:0] word,
  output tick_t            tick
);

  logic key_right, key_center, key_left, key_power;
  logic pin_right_level, pin_center_level, pin_left_level;
  keys_t phys;

  assign key_right        = word[22];
  assign key_center       = word[23];
  assign key_left         = word[24];
  assign key_power        = word[25];
  assign pin_right_level  = word[26];
  assign pin_center_level = word[27];
  assign pin_left_level   = word[28];

  always_comb begin
    phys           = '0;
    phys[K_LEFT]    = key_left   | ~pin_left_level;
    phys[K_CONFIRM] = key_center | ~pin_center_level;
    phys[K_RIGHT]   = key_right  | ~pin_right_level;
    phys[K_POWER]   = key_power;
  end

  always_comb begin
    tick.enabled   = word[0];
    tick.down      = word[1];
    tick.col       = word[11:2];
    tick.row       = word[21:12];
    tick.phys_keys = phys;
    tick.zone_keys = zone_bit(word[11:2], word[21:12]);
    tick.now       = word[60:29];
  end

  logic unused_pad;
  assign unused_pad = ^word[63:61];

endmodule

`default_nettype wire

// ----- rtl/btiq_queue.sv -----
// two-entry queue of classified ticks between front and back
`default_nettype none

module btiq_queue
  import btiq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  tick_t      push_data,
  output logic       not_full,
  input  wire logic  pop,
  output logic       not_empty,
  output tick_t      pop_data
);

  tick_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic  [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/btiq_back.sv -----
// back end: touch tracking, tap judgement, key edges, hold time and output register
`default_nettype none

module btiq_back
  import btiq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data,
  input  wire logic                 tick_valid,
  input  tick_t                     tick,
  output logic                      tick_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [79:0]               out_word
);

  logic [TMO_BITS-1:0]  tap_timeout_ms;
  logic [TRAV_BITS-1:0] travel_limit;

  keys_t  prev_keys;
  logic   touch_active;
  coord_t touch_col;
  coord_t touch_row;
  keys_t  touch_zone;
  coord_t start_col;
  coord_t start_row;
  ms_t    start_time;
  ms_t    press_time;

  logic   down_eff;
  logic   tap;
  ms_t    dur;
  coord_t dx, dy;
  keys_t  keys, pressed, released;
  ms_t    held;
  coord_t col_next, row_next;

  assign tick_pop = tick_valid && (!out_valid || out_ready);

  always_comb begin
    down_eff = tick.enabled & tick.down;
    dur      = tick.now - start_time;
    dx       = (touch_col >= start_col) ? touch_col - start_col : start_col - touch_col;
    dy       = (touch_row >= start_row) ? touch_row - start_row : start_row - touch_row;
    // a tap is judged only on a release while enabled
    tap      = tick.enabled && !tick.down && touch_active &&
               (dur <= {{(TIME_BITS-TMO_BITS){1'b0}}, tap_timeout_ms}) &&
               (dx <= travel_limit) && (dy <= travel_limit);
    keys     = tick.phys_keys | (down_eff ? tick.zone_keys : '0) | (tap ? touch_zone : '0);
    pressed  = (keys ^ prev_keys) & keys;
    released = (keys ^ prev_keys) & prev_keys;
    if (keys == '0) begin
      held = '0;
    end else if (pressed != '0) begin
      held = '0;
    end else begin
      held = tick.now - press_time;
    end
    col_next = down_eff ? tick.col : touch_col;
    row_next = down_eff ? tick.row : touch_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_timeout_ms <= TMO_BITS'(300);
      travel_limit   <= TRAV_BITS'(20);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TAP_TIMEOUT: tap_timeout_ms <= cfg_data;
        REG_TAP_TRAVEL:  travel_limit   <= cfg_data[TRAV_BITS-1:0];
        default:         tap_timeout_ms <= tap_timeout_ms;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys    <= '0;
      touch_active <= 1'b0;
      touch_col    <= '0;
      touch_row    <= '0;
      touch_zone   <= '0;
      start_col    <= '0;
      start_row    <= '0;
      start_time   <= '0;
      press_time   <= '0;
    end else if (tick_pop) begin
      prev_keys    <= keys;
      touch_active <= down_eff;
      if (down_eff) begin
        touch_col  <= tick.col;
        touch_row  <= tick.row;
        touch_zone <= tick.zone_keys;
        if (!touch_active) begin
          start_col  <= tick.col;
          start_row  <= tick.row;
          start_time <= tick.now;
        end
      end
      if (pressed != '0) begin
        press_time <= tick.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_pop) begin
      out_word <= {5'b0, held, row_next, col_next, down_eff, tap, released, pressed, keys};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/button_touch_input_qualifier.sv -----
// top level of the button and touch input qualifier
//
// channel    | dir | handshake              | word
// -----------+-----+------------------------+------------------------------------------
// poll tick  | in  | s_tvalid / s_tready    | s_tdata, 64 bits
// result     | out | m_tvalid / m_tready    | m_tdata, 80 bits
// config     | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// one word per cycle sustained while m_tready stays high; a tick is written into the queue
// at the edge that takes it, and its result is put on m_tdata by the back-end output register
// the two-entry queue lets the front take up to two more words while a result waits on m_tready
// rst is synchronous; the block takes words on the first cycle after reset
`default_nettype none

module button_touch_input_qualifier
  import btiq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // touch_enabled, touch_down, touch_col, touch_row, key_right, key_center, key_left,
  // key_power, pin_right_level, pin_center_level, pin_left_level, now_ms
  input  wire logic [63:0]         s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // key_state, press_edges, release_edges, tap_seen, touch_now, touch_last_col,
  // touch_last_row, held_ms
  output logic [79:0]              m_tdata
);

  tick_t front_tick;
  tick_t back_tick;
  logic  q_not_full;
  logic  q_not_empty;
  logic  q_pop;

  btiq_front u_front (
    .word (s_tdata),
    .tick (front_tick)
  );

  assign s_tready = q_not_full;

  btiq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && q_not_full),
    .push_data (front_tick),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (back_tick)
  );

  btiq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (q_not_empty),
    .tick       (back_tick),
    .tick_pop   (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_word   (m_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the button and touch input qualifier, stream in and stream out
`default_nettype none

module tb_top;
  import btiq_pkg::*;

  // one poll tick, first declared field sits in the top bits
  typedef struct packed {
    ms_t    now;
    logic   pin_left;
    logic   pin_center;
    logic   pin_right;
    logic   k_power;
    logic   k_left;
    logic   k_center;
    logic   k_right;
    coord_t row;
    coord_t col;
    logic   down;
    logic   enabled;
  } poll_t;

  // one result word, same packing rule
  typedef struct packed {
    ms_t    held;
    coord_t row;
    coord_t col;
    logic   touch_now;
    logic   tap;
    keys_t  released;
    keys_t  pressed;
    keys_t  keys;
  } outcome_t;

  typedef struct {
    poll_t    p;
    logic     known;
    outcome_t want;
  } plan_row_t;

  localparam int     WATCH_LIMIT = 4000;
  localparam int     HOLD_CYCLES = 300;
  localparam int     SEG_ITEMS   = 185;
  localparam keys_t  PWR_BIT     = keys_t'(1) << K_POWER;
  localparam keys_t  FRONT_BITS  = (keys_t'(1) << K_LEFT) | (keys_t'(1) << K_CONFIRM) |
                                   (keys_t'(1) << K_RIGHT);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = REG_TAP_TIMEOUT;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [63:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [79:0]         m_tdata;

  button_touch_input_qualifier uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // touch rectangles, first match wins
  int zone_x   [6] = '{40, 480, 840, 40, 840, 880};
  int zone_y   [6] = '{480, 480, 480, 240, 240, 40};
  int zone_key [6] = '{K_LEFT, K_CONFIRM, K_RIGHT, K_UP, K_DOWN, K_BACK};

  // shadow of the block's registers and state
  logic [15:0] tmo_cfg;
  logic [9:0]  travel_cfg;
  keys_t       last_keys;
  logic        tch_active;
  coord_t      tch_col, tch_row, org_col, org_row;
  ms_t         org_time, press_stamp;

  outcome_t    due_results [$];
  int          n_mismatch = 0;
  int          n_results = 0;
  int          n_taps = 0;
  int          n_sent = 0;
  int          send_idle = 10;
  int          recv_idle = 82;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_run = 0;

  function automatic keys_t rect_key(input coord_t x, input coord_t y);
    for (int i = 0; i < 6; i++) begin
      if (int'(x) >= zone_x[i] && int'(x) < zone_x[i] + 80 &&
          int'(y) >= zone_y[i] && int'(y) < zone_y[i] + 40) begin
        return keys_t'(1) << zone_key[i];
      end
    end
    return '0;
  endfunction

  function automatic outcome_t qualify_tick(input poll_t p);
    outcome_t    r;
    logic        was;
    coord_t      lc, lr;
    keys_t       keys, pend, chg;
    ms_t         dur;
    logic [9:0]  dc, dr;
    r    = '0;
    was  = tch_active;
    lc   = tch_col;
    lr   = tch_row;
    pend = '0;
    if (!p.enabled) begin
      tch_active = 1'b0;
    end else if (p.down) begin
      tch_active = 1'b1;
      tch_col    = p.col;
      tch_row    = p.row;
      if (!was) begin
        org_time = p.now;
        org_col  = p.col;
        org_row  = p.row;
      end
    end else begin
      tch_active = 1'b0;
      if (was) begin
        dur = p.now - org_time;
        dc  = (lc >= org_col) ? lc - org_col : org_col - lc;
        dr  = (lr >= org_row) ? lr - org_row : org_row - lr;
        if (dur <= {16'b0, tmo_cfg} && dc <= travel_cfg && dr <= travel_cfg) begin
          r.tap = 1'b1;
          pend  = rect_key(lc, lr);
        end
      end
    end
    keys            = '0;
    keys[K_LEFT]    = p.k_left | ~p.pin_left;
    keys[K_CONFIRM] = p.k_center | ~p.pin_center;
    keys[K_RIGHT]   = p.k_right | ~p.pin_right;
    keys[K_POWER]   = p.k_power;
    if (tch_active) begin
      keys = keys | rect_key(tch_col, tch_row);
    end
    keys       = keys | pend;
    chg        = keys ^ last_keys;
    r.pressed  = chg & keys;
    r.released = chg & last_keys;
    if (r.pressed != '0) begin
      press_stamp = p.now;
    end
    r.held      = (keys != '0) ? p.now - press_stamp : '0;
    last_keys   = keys;
    r.keys      = keys;
    r.touch_now = tch_active;
    r.col       = tch_col;
    r.row       = tch_row;
    return r;
  endfunction

  // k: {power, left, center, right}; pins: {left, center, right}
  function automatic poll_t mk_poll(input logic en, input logic dn, input int col, input int row,
                                    input logic [3:0] k, input logic [2:0] pins, input ms_t now);
    poll_t p;
    p.enabled    = en;
    p.down       = dn;
    p.col        = coord_t'(col);
    p.row        = coord_t'(row);
    p.k_right    = k[0];
    p.k_center   = k[1];
    p.k_left     = k[2];
    p.k_power    = k[3];
    p.pin_right  = pins[0];
    p.pin_center = pins[1];
    p.pin_left   = pins[2];
    p.now        = now;
    return p;
  endfunction

  function automatic outcome_t mk_out(input keys_t k, input keys_t pr, input keys_t rl,
                                      input logic tap, input logic tn, input coord_t c,
                                      input coord_t r, input ms_t h);
    outcome_t o;
    o.keys      = k;
    o.pressed   = pr;
    o.released  = rl;
    o.tap       = tap;
    o.touch_now = tn;
    o.col       = c;
    o.row       = r;
    o.held      = h;
    return o;
  endfunction

  function automatic int clip(input int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_mismatch < 40) begin
      $display("mismatch on result %0d: %s got %0h want %0h", n_results, what, got, want);
    end
    n_mismatch++;
  endtask

  task automatic offer_tick(input poll_t p, input logic known, input outcome_t typed);
    outcome_t pred;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = qualify_tick(p);
    due_results.push_back(known ? typed : pred);
    n_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TAP_TIMEOUT) begin
      tmo_cfg = val;
    end else begin
      travel_cfg = val[9:0];
    end
    @(posedge clk);
  endtask

  // receiver: random back-pressure plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = outcome_t'(m_tdata[74:0]);
        if (due_results.size() == 0) begin
          report_mismatch("word with nothing expected", got.held, '0);
        end else begin
          want = due_results.pop_front();
          if (got.keys !== want.keys) report_mismatch("key_state", got.keys, want.keys);
          if (got.pressed !== want.pressed)
            report_mismatch("press_edges", got.pressed, want.pressed);
          if (got.released !== want.released)
            report_mismatch("release_edges", got.released, want.released);
          if (got.tap !== want.tap) report_mismatch("tap_seen", got.tap, want.tap);
          if (got.touch_now !== want.touch_now)
            report_mismatch("touch_now", got.touch_now, want.touch_now);
          if (got.col !== want.col) report_mismatch("touch_last_col", got.col, want.col);
          if (got.row !== want.row) report_mismatch("touch_last_row", got.row, want.row);
          if (got.held !== want.held) report_mismatch("held_ms", got.held, want.held);
        end
        if (got.tap === 1'b1) n_taps++;
        n_results++;
        quiet_run = 0;
      end else if (s_tvalid && s_tready) begin
        quiet_run = 0;
      end else begin
        quiet_run++;
      end
      if (quiet_run >= WATCH_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCH_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t   plan [25];
    int          seg_start, roll, z, moves, d, sx, sy, px, py, extra;
    ms_t         wall_ms, t0, dur;
    logic [3:0]  btn_k;
    logic [2:0]  btn_p;

    tmo_cfg     = 16'd300;
    travel_cfg  = 10'd20;
    last_keys   = '0;
    tch_active  = 1'b0;
    tch_col     = '0;
    tch_row     = '0;
    org_col     = '0;
    org_row     = '0;
    org_time    = '0;
    press_stamp = '0;
    wall_ms     = 32'd10000;
    btn_k       = 4'h0;
    btn_p       = 3'h7;

    // after reset, single keys, pins, time extremes
    plan[0]  = '{mk_poll(0, 0, 0, 0, 4'h0, 3'h7, 100), 1'b1, mk_out(0, 0, 0, 0, 0, 0, 0, 0)};
    plan[1]  = '{mk_poll(0, 0, 0, 0, 4'h8, 3'h7, 200), 1'b1,
                 mk_out(PWR_BIT, PWR_BIT, 0, 0, 0, 0, 0, 0)};
    plan[2]  = '{mk_poll(0, 0, 0, 0, 4'h0, 3'h0, 250), 1'b1,
                 mk_out(FRONT_BITS, FRONT_BITS, PWR_BIT, 0, 0, 0, 0, 0)};
    plan[3]  = '{mk_poll(0, 0, 1023, 1023, 4'h0, 3'h0, 32'hFFFF_FFFF), 1'b1,
                 mk_out(FRONT_BITS, 0, 0, 0, 0, 0, 0, 32'hFFFF_FF05)};
    // release with no touch behind it
    plan[4]  = '{mk_poll(1, 0, 1023, 1023, 4'h7, 3'h7, 300), 1'b0, '0};
    plan[5]  = '{mk_poll(1, 0, 0, 0, 4'h0, 3'h7, 310), 1'b0, '0};
    // tap on the confirm rectangle
    plan[6]  = '{mk_poll(1, 1, 500, 490, 4'h0, 3'h7, 1000), 1'b0, '0};
    plan[7]  = '{mk_poll(1, 1, 510, 495, 4'h0, 3'h7, 1050), 1'b0, '0};
    plan[8]  = '{mk_poll(1, 0, 0, 0, 4'h0, 3'h7, 1100), 1'b0, '0};
    plan[9]  = '{mk_poll(1, 0, 0, 0, 4'h0, 3'h7, 1110), 1'b0, '0};
    // tap outside every rectangle, duration right on the timeout
    plan[10] = '{mk_poll(1, 1, 1023, 1023, 4'h0, 3'h7, 2000), 1'b0, '0};
    plan[11] = '{mk_poll(1, 0, 5, 5, 4'h0, 3'h7, 2300), 1'b0, '0};
    // rectangle corner, then one past it, held too long
    plan[12] = '{mk_poll(1, 1, 119, 519, 4'h0, 3'h7, 3000), 1'b0, '0};
    plan[13] = '{mk_poll(1, 1, 120, 520, 4'h0, 3'h7, 3010), 1'b0, '0};
    plan[14] = '{mk_poll(1, 0, 0, 0, 4'h0, 3'h7, 3301), 1'b0, '0};
    // touch dropped by disable, then a stray release
    plan[15] = '{mk_poll(1, 1, 40, 240, 4'h0, 3'h7, 4000), 1'b0, '0};
    plan[16] = '{mk_poll(0, 1, 60, 250, 4'h0, 3'h7, 4010), 1'b0, '0};
    plan[17] = '{mk_poll(1, 0, 60, 250, 4'h0, 3'h7, 4020), 1'b0, '0};
    // tap across the timestamp wrap, travel right on the limit
    plan[18] = '{mk_poll(1, 1, 880, 40, 4'h0, 3'h7, 32'hFFFF_FF00), 1'b0, '0};
    plan[19] = '{mk_poll(1, 1, 900, 60, 4'h0, 3'h7, 32'hFFFF_FFF0), 1'b0, '0};
    plan[20] = '{mk_poll(1, 0, 0, 0, 4'h0, 3'h7, 32'h0000_0020), 1'b0, '0};
    // travel one past the limit
    plan[21] = '{mk_poll(1, 1, 0, 0, 4'hF, 3'h7, 5000), 1'b0, '0};
    plan[22] = '{mk_poll(1, 1, 21, 0, 4'hF, 3'h7, 5005), 1'b0, '0};
    plan[23] = '{mk_poll(1, 0, 0, 0, 4'hF, 3'h7, 5010), 1'b0, '0};
    plan[24] = '{mk_poll(1, 0, 0, 0, 4'h0, 3'h7, 6000), 1'b0, '0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      offer_tick(plan[i].p, plan[i].known, plan[i].want);
    end

    for (int seg = 0; seg < 6; seg++) begin
      send_idle = (seg < 2) ? 10 : (seg < 4) ? 82 : 0;
      recv_idle = (seg < 2) ? 82 : (seg < 4) ? 10 : 0;
      if (seg > 0) begin
        settle();
        case (seg)
          1: begin
            write_reg(REG_TAP_TIMEOUT, 16'd0);
            write_reg(REG_TAP_TRAVEL, 16'd0);
          end
          2: begin
            write_reg(REG_TAP_TIMEOUT, 16'hFFFF);
            write_reg(REG_TAP_TRAVEL, 16'd1023);
          end
          3: begin
            write_reg(REG_TAP_TIMEOUT, 16'($urandom_range(0, 65535)));
            write_reg(REG_TAP_TRAVEL, 16'($urandom_range(0, 1023)));
          end
          4: begin
            write_reg(REG_TAP_TIMEOUT, 16'd40);
            write_reg(REG_TAP_TRAVEL, 16'd3);
          end
          default: begin
            write_reg(REG_TAP_TIMEOUT, 16'd300);
            write_reg(REG_TAP_TRAVEL, 16'd20);
          end
        endcase
      end
      seg_start = n_sent;
      while (n_sent - seg_start < SEG_ITEMS) begin
        // long receiver stall while the sender keeps pushing
        if ((seg == 0 || seg == 4) && n_sent - seg_start >= SEG_ITEMS / 2 &&
            hold_asks == (seg == 0 ? 0 : 1)) begin
          hold_asks++;
        end
        if ($urandom_range(7) == 0) btn_k = 4'($urandom_range(15));
        if ($urandom_range(7) == 0) btn_p = 3'($urandom_range(7));
        if ($urandom_range(49) == 0) wall_ms = $urandom;
        roll = $urandom_range(99);
        if (roll < 80) begin
          if ($urandom_range(99) < 70) begin
            z  = $urandom_range(5);
            sx = zone_x[z] - 1 + $urandom_range(0, 81);
            sy = zone_y[z] - 1 + $urandom_range(0, 41);
          end else begin
            sx = $urandom_range(0, 1023);
            sy = $urandom_range(0, 1023);
          end
          t0 = wall_ms;
          offer_tick(mk_poll(1, 1, sx, sy, btn_k, btn_p, wall_ms), 1'b0, '0);
          moves = $urandom_range(0, 4);
          for (int m = 0; m < moves; m++) begin
            case ($urandom_range(5))
              0:       d = 0;
              1:       d = int'(travel_cfg);
              2:       d = int'(travel_cfg) + 1;
              3:       d = $urandom_range(0, travel_cfg);
              4:       d = $urandom_range(0, 1023);
              default: d = $urandom_range(1, 3);
            endcase
            px = sx;
            py = sy;
            if ($urandom_range(2) != 1) px = clip($urandom_range(1) ? sx + d : sx - d);
            if ($urandom_range(2) != 0) py = clip($urandom_range(1) ? sy + d : sy - d);
            wall_ms = wall_ms + $urandom_range(0, 5);
            offer_tick(mk_poll(1, 1, px, py, btn_k, btn_p, wall_ms), 1'b0, '0);
          end
          case ($urandom_range(5))
            0:       dur = '0;
            1:       dur = {16'b0, tmo_cfg};
            2:       dur = {16'b0, tmo_cfg} + 1;
            3:       dur = $urandom_range(0, tmo_cfg);
            4:       dur = {16'b0, tmo_cfg} + $urandom_range(2, 500);
            default: dur = $urandom;
          endcase
          wall_ms = t0 + dur;
          offer_tick(mk_poll($urandom_range(9) != 0, 0, $urandom_range(1023),
                             $urandom_range(1023), btn_k, btn_p, wall_ms), 1'b0, '0);
          extra = $urandom_range(0, 2);
          for (int j = 0; j < extra; j++) begin
            wall_ms = wall_ms + $urandom_range(1, 50);
            offer_tick(mk_poll(1, 0, $urandom_range(1023), $urandom_range(1023), btn_k, btn_p,
                               wall_ms), 1'b0, '0);
          end
        end else begin
          extra = $urandom_range(1, 3);
          for (int j = 0; j < extra; j++) begin
            wall_ms = ($urandom_range(9) == 0) ? $urandom : wall_ms + $urandom_range(0, 100);
            offer_tick(mk_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                               $urandom_range(1023), $urandom_range(1023),
                               4'($urandom_range(15)), 3'($urandom_range(7)), wall_ms),
                       1'b0, '0);
          end
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d poll words and %0d result words, %0d of them taps,",
             n_sent, n_results, n_taps);
    $display("over six timeout and travel settings and three back-pressure mixes");
    if (n_mismatch == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
